### sv/gscb_pkg.sv
`default_nettype none

package gscb_pkg;

   localparam int BUTTONS_DEF = 10;

   localparam int AXIS_W = 8;    // raw stick axis
   localparam int DEAD_W = 7;    // dead radius register
   localparam int MAXR_W = 8;    // max radius register
   localparam int CSR_W  = 8;    // config write data
   localparam int SUM_W  = 16;   // x^2 + y^2, at most 32768
   localparam int PROD_W = 16;   // |axis| * max radius
   localparam int DIVN_W = 48;   // (|axis| * max * 256)^2
   localparam int QUO_W  = 32;   // quotient stays below 2^32
   localparam int RAD_W  = 32;   // square root radicand
   localparam int ROOT_W = 16;
   localparam int RREM_W = 18;   // root remainder, at most 2 * root
   localparam int OUT_W  = 16;   // Q8.8 outputs
   localparam int CNT_W  = 6;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVN_W - 1);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(RAD_W / 2 - 1);

   // config register indexes
   localparam logic CSR_DEAD_RADIUS = 1'b0;
   localparam logic CSR_MAX_RADIUS  = 1'b1;

   localparam logic [DEAD_W-1:0] DEAD_RESET = DEAD_W'(8);
   localparam logic [MAXR_W-1:0] MAXR_RESET = MAXR_W'(64);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SQR   = 9'b000000010,
      ST_CLASS = 9'b000000100,
      ST_PSQ   = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_RINIT = 9'b000100000,
      ST_ROOT  = 9'b001000000,
      ST_STORE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;          // latch input word, update button history
      logic square;        // s = x^2 + y^2, axis products
      logic classify;      // preset axis and magnitude results
      logic psq;           // load divider with squared scaled axis
      logic div_step;
      logic root_init;
      logic root_src_quo;  // radicand is quotient, else s << 16
      logic root_step;
      logic store_axis;
      logic store_mag;
      logic axis;          // 0: x, 1: y
      logic emit;          // load the output register
   } cmd_type;

   typedef struct packed {
      logic is_dead;
      logic is_scale;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### sv/gscb_ctrl.sv
`default_nettype none

module gscb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire gscb_pkg::status_type status,
   output gscb_pkg::cmd_type       cmd
);

   gscb_pkg::state_type state_ff, state_in;
   logic [gscb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic axis_ff, axis_in;

   assign req_ready = (state_ff == gscb_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         gscb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = gscb_pkg::ST_SQR;
            end
         end
         gscb_pkg::ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = gscb_pkg::ST_CLASS;
         end
         gscb_pkg::ST_CLASS: begin
            cmd.classify = 1'b1;
            axis_in      = 1'b0;
            if (status.is_dead) begin
               state_in = gscb_pkg::ST_DONE;
            end else if (status.is_scale) begin
               state_in = gscb_pkg::ST_PSQ;
            end else begin
               state_in = gscb_pkg::ST_RINIT;
            end
         end
         gscb_pkg::ST_PSQ: begin
            cmd.psq  = 1'b1;
            cnt_in   = gscb_pkg::DIV_LAST;
            state_in = gscb_pkg::ST_DIV;
         end
         gscb_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = gscb_pkg::ST_RINIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         gscb_pkg::ST_RINIT: begin
            cmd.root_init    = 1'b1;
            cmd.root_src_quo = status.is_scale;
            cnt_in           = gscb_pkg::ROOT_LAST;
            state_in         = gscb_pkg::ST_ROOT;
         end
         gscb_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = gscb_pkg::ST_STORE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         gscb_pkg::ST_STORE: begin
            if (status.is_scale) begin
               cmd.store_axis = 1'b1;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = gscb_pkg::ST_PSQ;
               end else begin
                  state_in = gscb_pkg::ST_DONE;
               end
            end else begin
               cmd.store_mag = 1'b1;
               state_in      = gscb_pkg::ST_DONE;
            end
         end
         gscb_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = gscb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gscb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gscb_pkg::ST_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

`default_nettype wire

### sv/gscb_dpath.sv
`default_nettype none

module gscb_dpath #(
   parameter int BUTTONS = gscb_pkg::BUTTONS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [BUTTONS-1:0]                req_button_levels,
   input  wire logic signed [gscb_pkg::AXIS_W-1:0] req_stick_x,
   input  wire logic signed [gscb_pkg::AXIS_W-1:0] req_stick_y,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_index,
   input  wire logic [gscb_pkg::CSR_W-1:0]        csr_data,
   input  wire gscb_pkg::cmd_type                 cmd,
   output gscb_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [BUTTONS-1:0]                     rsp_held,
   output logic [BUTTONS-1:0]                     rsp_pressed,
   output logic [BUTTONS-1:0]                     rsp_released,
   output logic signed [gscb_pkg::OUT_W-1:0]      rsp_out_x,
   output logic signed [gscb_pkg::OUT_W-1:0]      rsp_out_y,
   output logic [gscb_pkg::OUT_W-1:0]             rsp_magnitude
);

   // config
   logic [gscb_pkg::DEAD_W-1:0] dead_ff;
   logic [gscb_pkg::MAXR_W-1:0] maxr_ff;

   // button history and current word
   logic [BUTTONS-1:0] prev_held_ff;
   logic [BUTTONS-1:0] held_ff, pressed_ff, released_ff;
   logic [gscb_pkg::AXIS_W-1:0] x_ff, y_ff;

   // working registers
   logic [gscb_pkg::SUM_W-1:0]  s_ff;
   logic [gscb_pkg::PROD_W-1:0] px_ff, py_ff;
   logic [gscb_pkg::DIVN_W-1:0] div_num_ff;
   logic [gscb_pkg::SUM_W-1:0]  div_rem_ff;
   logic [gscb_pkg::QUO_W-1:0]  quo_ff;
   logic [gscb_pkg::RAD_W-1:0]  rad_ff;
   logic [gscb_pkg::RREM_W-1:0] rrem_ff;
   logic [gscb_pkg::ROOT_W-1:0] root_ff;
   logic [gscb_pkg::OUT_W-1:0]  ax_x_ff, ax_y_ff, mag_ff;

   // output register
   logic                       rsp_valid_ff;
   logic [BUTTONS-1:0]         o_held_ff, o_pressed_ff, o_released_ff;
   logic [gscb_pkg::OUT_W-1:0] o_x_ff, o_y_ff, o_mag_ff;

   logic [gscb_pkg::AXIS_W-1:0]   x_abs, y_abs;
   logic [2*gscb_pkg::DEAD_W-1:0] dead_sq;
   logic [gscb_pkg::SUM_W-1:0]    maxr_sq;
   logic [gscb_pkg::PROD_W-1:0]   p_sel;
   logic [gscb_pkg::SUM_W:0]      rem_sh;
   logic                          div_ge;
   logic [gscb_pkg::RREM_W+1:0]   rrem_sh, trial;
   logic                          root_ge;
   logic [gscb_pkg::OUT_W-1:0]    lim;
   logic                          zero_x, zero_y;
   logic [gscb_pkg::OUT_W-1:0]    ox, oy;

   assign x_abs = x_ff[gscb_pkg::AXIS_W-1] ? (~x_ff + 1'b1) : x_ff;
   assign y_abs = y_ff[gscb_pkg::AXIS_W-1] ? (~y_ff + 1'b1) : y_ff;

   assign dead_sq = (2*gscb_pkg::DEAD_W)'({{gscb_pkg::DEAD_W{1'b0}}, dead_ff}
                                          * {{gscb_pkg::DEAD_W{1'b0}}, dead_ff});
   assign maxr_sq = gscb_pkg::SUM_W'({{gscb_pkg::MAXR_W{1'b0}}, maxr_ff}
                                     * {{gscb_pkg::MAXR_W{1'b0}}, maxr_ff});

   assign status.is_dead  = s_ff < {{(gscb_pkg::SUM_W - 2*gscb_pkg::DEAD_W){1'b0}}, dead_sq};
   assign status.is_scale = s_ff > maxr_sq;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign p_sel = cmd.axis ? py_ff : px_ff;

   // restoring divide, one quotient bit per step
   assign rem_sh = {div_rem_ff, div_num_ff[gscb_pkg::DIVN_W-1]};
   assign div_ge = rem_sh >= {1'b0, s_ff};

   // digit-by-digit square root, two radicand bits per step
   assign rrem_sh = {rrem_ff, rad_ff[gscb_pkg::RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = rrem_sh >= trial;

   // per-axis dead zone on the Q8.8 magnitude
   assign lim    = {1'b0, dead_ff, 8'b0};
   assign zero_x = status.is_dead || (ax_x_ff < lim);
   assign zero_y = status.is_dead || (ax_y_ff < lim);
   assign ox = zero_x ? '0 : (x_ff[gscb_pkg::AXIS_W-1] ? (~ax_x_ff + 1'b1) : ax_x_ff);
   assign oy = zero_y ? '0 : (y_ff[gscb_pkg::AXIS_W-1] ? (~ax_y_ff + 1'b1) : ax_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff      <= gscb_pkg::DEAD_RESET;
         maxr_ff      <= gscb_pkg::MAXR_RESET;
         prev_held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               gscb_pkg::CSR_DEAD_RADIUS: dead_ff <= csr_data[gscb_pkg::DEAD_W-1:0];
               gscb_pkg::CSR_MAX_RADIUS:  maxr_ff <= csr_data[gscb_pkg::MAXR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            prev_held_ff <= req_button_levels;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         held_ff     <= req_button_levels;
         pressed_ff  <= req_button_levels & ~prev_held_ff;
         released_ff <= prev_held_ff & ~req_button_levels;
         x_ff        <= req_stick_x;
         y_ff        <= req_stick_y;
      end
      if (cmd.square) begin
         s_ff  <= gscb_pkg::SUM_W'({8'b0, x_abs} * {8'b0, x_abs})
                + gscb_pkg::SUM_W'({8'b0, y_abs} * {8'b0, y_abs});
         px_ff <= gscb_pkg::PROD_W'({8'b0, x_abs} * {8'b0, maxr_ff});
         py_ff <= gscb_pkg::PROD_W'({8'b0, y_abs} * {8'b0, maxr_ff});
      end
      if (cmd.classify) begin
         ax_x_ff <= {x_abs, 8'b0};
         ax_y_ff <= {y_abs, 8'b0};
         mag_ff  <= {maxr_ff, 8'b0};
      end
      if (cmd.psq) begin
         div_num_ff <= {gscb_pkg::QUO_W'({16'b0, p_sel} * {16'b0, p_sel}), 16'b0};
         div_rem_ff <= '0;
         quo_ff     <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[gscb_pkg::DIVN_W-2:0], 1'b0};
         div_rem_ff <= div_ge ? gscb_pkg::SUM_W'(rem_sh - {1'b0, s_ff})
                              : rem_sh[gscb_pkg::SUM_W-1:0];
         quo_ff     <= {quo_ff[gscb_pkg::QUO_W-2:0], div_ge};
      end
      if (cmd.root_init) begin
         rad_ff  <= cmd.root_src_quo ? quo_ff : {s_ff, 16'b0};
         rrem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[gscb_pkg::RAD_W-3:0], 2'b00};
         rrem_ff <= root_ge ? gscb_pkg::RREM_W'(rrem_sh - trial)
                            : rrem_sh[gscb_pkg::RREM_W-1:0];
         root_ff <= {root_ff[gscb_pkg::ROOT_W-2:0], root_ge};
      end
      if (cmd.store_axis) begin
         if (cmd.axis) begin
            ax_y_ff <= root_ff;
         end else begin
            ax_x_ff <= root_ff;
         end
      end
      if (cmd.store_mag) begin
         mag_ff <= root_ff;
      end
      if (cmd.emit) begin
         o_held_ff     <= held_ff;
         o_pressed_ff  <= pressed_ff;
         o_released_ff <= released_ff;
         o_x_ff        <= ox;
         o_y_ff        <= oy;
         o_mag_ff      <= status.is_dead ? '0 : mag_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_held      = o_held_ff;
   assign rsp_pressed   = o_pressed_ff;
   assign rsp_released  = o_released_ff;
   assign rsp_out_x     = o_x_ff;
   assign rsp_out_y     = o_y_ff;
   assign rsp_magnitude = o_mag_ff;

endmodule

`default_nettype wire

### sv/gamepad_stick_and_button_conditioner.sv
`default_nettype none

// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  --------------------------------------------
// req_      in         req_valid/req_ready   button_levels, stick_x, stick_y
// rsp_      out        rsp_valid/rsp_ready   held, pressed, released, out_x, out_y, magnitude
// csr_      in         csr_valid/csr_ready   csr_index (0 dead radius, 1 max radius), csr_data
//
// One word in flight at a time. Inside the dead radius a word is only squared and
// classified, inside the max radius it adds a 16-step square root, and a scaled stick
// takes per axis a 48-step restoring divide plus a 16-step square root.
// The output register frees the next word to start while a result waits.
// Synchronous active-high reset: dead radius 8, max radius 64, history clear.
// csr_ready is always high; rsp_ready low holds the finished word and the next one behind it.

module gamepad_stick_and_button_conditioner #(
   parameter int BUTTONS = gscb_pkg::BUTTONS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [BUTTONS-1:0]                 req_button_levels,
   input  wire logic signed [gscb_pkg::AXIS_W-1:0] req_stick_x,
   input  wire logic signed [gscb_pkg::AXIS_W-1:0] req_stick_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [BUTTONS-1:0]                      rsp_held,
   output logic [BUTTONS-1:0]                      rsp_pressed,
   output logic [BUTTONS-1:0]                      rsp_released,
   output logic signed [gscb_pkg::OUT_W-1:0]       rsp_out_x,
   output logic signed [gscb_pkg::OUT_W-1:0]       rsp_out_y,
   output logic [gscb_pkg::OUT_W-1:0]              rsp_magnitude,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_index,
   input  wire logic [gscb_pkg::CSR_W-1:0]         csr_data
);

   gscb_pkg::cmd_type    cmd;
   gscb_pkg::status_type status;

   // registers are plain flops, each write lands on the next clock edge
   assign csr_ready = 1'b1;

   // sequencer: load, square, classify, then divide / root passes, then emit
   gscb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // button edges, radius tests, shared divider and square root, output register
   gscb_dpath #(
      .BUTTONS (BUTTONS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_button_levels (req_button_levels),
      .req_stick_x       (req_stick_x),
      .req_stick_y       (req_stick_y),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_held          (rsp_held),
      .rsp_pressed       (rsp_pressed),
      .rsp_released      (rsp_released),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_magnitude     (rsp_magnitude)
   );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int BUTTONS        = gscb_pkg::BUTTONS_DEF;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int RANDOM_PHASES  = 7;     // last one runs without idling
   localparam int PHASE_WORDS    = 72;

   // one conditioned poll as it leaves the block
   typedef struct {
      logic [BUTTONS-1:0]               held;
      logic [BUTTONS-1:0]               pressed;
      logic [BUTTONS-1:0]               released;
      logic signed [gscb_pkg::OUT_W-1:0] out_x;
      logic signed [gscb_pkg::OUT_W-1:0] out_y;
      logic [gscb_pkg::OUT_W-1:0]        magnitude;
   } poll_result_type;

   // Mirrors the radii and button history, predicts each poll on acceptance
   // and checks result words in order against the predictions.
   class stick_button_scoreboard;
      logic [gscb_pkg::DEAD_W-1:0] dead;
      logic [gscb_pkg::MAXR_W-1:0] maxr;
      logic [BUTTONS-1:0]          last_held;
      poll_result_type             due_polls[$];
      int                          errors;

      function new();
         dead      = gscb_pkg::DEAD_RESET;
         maxr      = gscb_pkg::MAXR_RESET;
         last_held = '0;
         errors    = 0;
      endfunction

      // floor of the square root, one result bit at a time
      static function longint unsigned root_floor(longint unsigned v);
         longint unsigned r, t;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      // sign(a) * floor(|a| * max * 256 / sqrt(s)), taken as a root of the square
      function int scaled_axis(int a, int s);
         longint unsigned n, q;
         n = longint'(a < 0 ? -a : a) * longint'(maxr) * 256;
         q = root_floor((n * n) / longint'(s));
         return a < 0 ? -int'(q) : int'(q);
      endfunction

      function void set_register(logic idx, logic [gscb_pkg::CSR_W-1:0] data);
         if (idx == gscb_pkg::CSR_DEAD_RADIUS) dead = data[gscb_pkg::DEAD_W-1:0];
         else                                  maxr = data[gscb_pkg::MAXR_W-1:0];
      endfunction

      function void predict_poll(logic [BUTTONS-1:0] levels,
                                 logic signed [gscb_pkg::AXIS_W-1:0] sx,
                                 logic signed [gscb_pkg::AXIS_W-1:0] sy);
         poll_result_type r;
         int x, y, s, d, m, ox, oy, mag, lim;
         x = sx;
         y = sy;
         d = dead;
         m = maxr;
         r.held     = levels;
         r.pressed  = levels & ~last_held;
         r.released = last_held & ~levels;
         last_held  = levels;

         s = x * x + y * y;
         if (s < d * d) begin
            // radial dead zone
            ox  = 0;
            oy  = 0;
            mag = 0;
         end else if (s > m * m) begin
            // beyond max radius: scale the vector, clamp the length
            ox  = scaled_axis(x, s);
            oy  = scaled_axis(y, s);
            mag = m << 8;
         end else begin
            ox  = x * 256;
            oy  = y * 256;
            mag = int'(root_floor(longint'(s) << 16));
         end

         // per-axis dead zone after scaling; magnitude left alone
         lim = d << 8;
         if (ox > -lim && ox < lim) ox = 0;
         if (oy > -lim && oy < lim) oy = 0;

         r.out_x     = ox[gscb_pkg::OUT_W-1:0];
         r.out_y     = oy[gscb_pkg::OUT_W-1:0];
         r.magnitude = mag[gscb_pkg::OUT_W-1:0];
         due_polls.push_back(r);
      endfunction

      function void compare(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(poll_result_type got);
         poll_result_type want;
         if (due_polls.size() == 0) begin
            $display("%0t: result word with nothing expected: held %h out_x %0d out_y %0d",
                     $time, got.held, got.out_x, got.out_y);
            errors++;
            return;
         end
         want = due_polls.pop_front();
         compare("held",      want.held,      got.held);
         compare("pressed",   want.pressed,   got.pressed);
         compare("released",  want.released,  got.released);
         compare("out_x",     want.out_x,     got.out_x);
         compare("out_y",     want.out_y,     got.out_y);
         compare("magnitude", want.magnitude, got.magnitude);
      endfunction

      function int pending();
         return due_polls.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [BUTTONS-1:0]                req_button_levels;
   logic signed [gscb_pkg::AXIS_W-1:0] req_stick_x;
   logic signed [gscb_pkg::AXIS_W-1:0] req_stick_y;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [BUTTONS-1:0]                rsp_held;
   logic [BUTTONS-1:0]                rsp_pressed;
   logic [BUTTONS-1:0]                rsp_released;
   logic signed [gscb_pkg::OUT_W-1:0]  rsp_out_x;
   logic signed [gscb_pkg::OUT_W-1:0]  rsp_out_y;
   logic [gscb_pkg::OUT_W-1:0]         rsp_magnitude;
   logic                              csr_valid;
   logic                              csr_ready;
   logic                              csr_index;
   logic [gscb_pkg::CSR_W-1:0]         csr_data;

   stick_button_scoreboard book = new();

   // idling knobs, set per phase by the stimulus thread
   int                 gap_pct   = 0;   // chance per word of a sender gap
   int                 stall_pct = 0;   // chance per cycle of a receiver stall
   bit                 calm      = 0;   // last stretch: no idling at all
   bit                 hold_req  = 0;   // ask receiver for the long hold-off
   int                 quiet_cycles = 0;
   logic [BUTTONS-1:0] last_levels = '0;

   gamepad_stick_and_button_conditioner #(
      .BUTTONS(BUTTONS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_button_levels (req_button_levels),
      .req_stick_x       (req_stick_x),
      .req_stick_y       (req_stick_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_held          (rsp_held),
      .rsp_pressed       (rsp_pressed),
      .rsp_released      (rsp_released),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_magnitude     (rsp_magnitude),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Monitors. Everything is sampled at the rising edge, so the values seen
   // are the pre-edge ones: a handshake counts exactly when the block sees it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      poll_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            book.predict_poll(req_button_levels, req_stick_x, req_stick_y);
         if (rsp_valid && rsp_ready) begin
            got.held      = rsp_held;
            got.pressed   = rsp_pressed;
            got.released  = rsp_released;
            got.out_x     = rsp_out_x;
            got.out_y     = rsp_out_y;
            got.magnitude = rsp_magnitude;
            book.check_result(got);
         end
         if (csr_valid && csr_ready)
            book.set_register(csr_index, csr_data);
      end
   end

   // Watchdog: any handshake restarts the count. Longest legal quiet spell is
   // the receiver hold-off plus one scaled poll, well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request so the
   // output register fills and the block backs up into req_ready.
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 0;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender tasks
   // ---------------------------------------------------------------------

   // Present one poll word and return on the edge that takes it. Valid is left
   // high so a back-to-back word just swaps the payload; anything else that
   // follows must drop req_valid itself.
   task automatic send_poll(input logic [BUTTONS-1:0] levels,
                            input logic signed [gscb_pkg::AXIS_W-1:0] sx,
                            input logic signed [gscb_pkg::AXIS_W-1:0] sy);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      req_stick_x       <= sx;
      req_stick_y       <= sy;
      last_levels        = levels;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait for every predicted result, then let it settle.
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // csr_valid stays up across back-to-back writes; program_radii drops it
   task automatic write_csr(input logic idx, input logic [gscb_pkg::CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Both radii are rewritten only with the block drained. Bit 7 of a dead
   // radius write is junk and must be dropped by the 7-bit register.
   task automatic program_radii(input int dead, input int maxr);
      wait_idle(8);
      write_csr(gscb_pkg::CSR_DEAD_RADIUS, {1'($urandom_range(0, 1)), 7'(dead)});
      write_csr(gscb_pkg::CSR_MAX_RADIUS, 8'(maxr));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [gscb_pkg::AXIS_W-1:0] clamp_axis(int v);
      if (v > 127)  return 8'sd127;
      if (v < -128) return -8'sd128;
      return gscb_pkg::AXIS_W'(v);
   endfunction

   // A point within a step of radius r, random quadrant.
   task automatic near_circle(input int r, output int x, output int y);
      x = $urandom_range(0, r);
      y = int'(stick_button_scoreboard::root_floor(longint'(r * r - x * x)));
      y = y + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
   endtask

   // One random poll: mostly points on or near the two radii and inside the
   // per-axis zone, with plain random and corner values mixed in.
   task automatic random_poll();
      logic [BUTTONS-1:0] levels;
      int x, y, lim;
      int corners[7] = '{-128, -127, -1, 0, 1, 126, 127};
      case ($urandom_range(0, 4))
         0:       levels = last_levels;
         1:       levels = last_levels ^ (BUTTONS'(1) << $urandom_range(0, BUTTONS - 1));
         2:       levels = $urandom_range(0, 1) ? '0 : '1;
         default: levels = BUTTONS'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            x = $signed(8'($urandom));
            y = $signed(8'($urandom));
         end
         3, 4:    near_circle(book.dead, x, y);
         5, 6, 7: near_circle(book.maxr, x, y);
         8: begin
            lim = book.dead + 2;
            x = $urandom_range(0, 2 * lim) - lim;
            y = $signed(8'($urandom));
            if ($urandom_range(0, 1)) begin
               x = y;
               y = $urandom_range(0, 2 * lim) - lim;
            end
         end
         default: begin
            x = corners[$urandom_range(0, 6)];
            y = corners[$urandom_range(0, 6)];
         end
      endcase
      send_poll(levels, clamp_axis(x), clamp_axis(y));
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int dead_pick, max_pick;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_button_levels <= '0;
      req_stick_x       <= '0;
      req_stick_y       <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= gscb_pkg::CSR_DEAD_RADIUS;
      csr_data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset radii (dead 8, max 64)
      stall_pct = 20;
      send_poll(10'h000,    0,    0);
      send_poll(10'h3ff,    7,    0);   // just inside dead radius
      send_poll(10'h3ff,    8,    0);   // on dead radius, axis kept
      send_poll(10'h000,   64,    0);   // on max radius, not scaled
      send_poll(10'h2aa,    0,  -64);
      send_poll(10'h155,   45,   45);   // just inside max radius
      send_poll(10'h2aa,   46,   46);   // just beyond, scaled
      send_poll(10'h155,  127,  127);
      send_poll(10'h3ff, -128, -128);
      send_poll(10'h3ff, -128,    0);
      send_poll(10'h000,  100,    5);   // scaled y falls into axis zone
      send_poll(10'h001,    5,   -7);   // both axes zeroed, magnitude kept

      // no dead zone, widest max radius that a stick can still exceed
      program_radii(0, 181);
      send_poll(10'h3fe,    0,    0);
      send_poll(10'h000, -128, -128);   // only corner beyond 181
      send_poll(10'h3ff,    1,   -1);
      send_poll(10'h200,  127, -128);

      // dead radius far above max radius
      program_radii(127, 1);
      send_poll(10'h1ff,  127,  127);   // scaled, then both axes zeroed
      send_poll(10'h000, -128,    0);
      send_poll(10'h3ff,  126,    0);   // radial dead zone

      program_radii(127, 181);
      send_poll(10'h155, -128, -128);

      // Random phases, fresh radii each time; the last one without idling
      for (int p = 0; p <= RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 4))
            0:       dead_pick = 0;
            1:       dead_pick = 127;
            2:       dead_pick = $urandom_range(0, 127);
            default: dead_pick = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 4))
            0:       max_pick = 1;
            1:       max_pick = 181;
            2:       max_pick = $urandom_range(1, 181);
            default: max_pick = $urandom_range(24, 127);
         endcase
         program_radii(dead_pick, max_pick);

         calm      = (p == RANDOM_PHASES);
         gap_pct   = calm ? 0 : $urandom_range(0, 3) * 15;
         stall_pct = calm ? 0 : $urandom_range(0, 3) * 10;
         // block fills up while the receiver sits on its hands
         if (p == 1) hold_req = 1;

         repeat (PHASE_WORDS) random_poll();
      end

      wait_idle(200);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
sv/gscb_pkg.sv
sv/gscb_ctrl.sv
sv/gscb_dpath.sv
sv/gamepad_stick_and_button_conditioner.sv
dv/tb.sv
